### design/pic_pkg.sv
// Shared types and constants of the priority interrupt controller.
package pic_pkg;

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_BYTE_RD = 6'b000100,
      ST_BYTE_WR = 6'b001000,
      ST_SCAN    = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      OP_PRIO_RD = 2'd0,
      OP_PRIO_WR = 2'd1,
      OP_SOFT_WR = 2'd2,
      OP_LINE    = 2'd3
   } op_type;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_LINE  = 2'd2;

   localparam logic CSR_VEC_SIZE = 1'b0;
   localparam logic CSR_VEC_BASE = 1'b1;

   localparam logic [13:0] ADDR_CFG        = 14'h000;
   localparam logic [13:0] ADDR_CFG_END    = 14'h003;
   localparam logic [13:0] ADDR_CURPRI     = 14'h008;
   localparam logic [13:0] ADDR_CURPRI_END = 14'h00B;
   localparam logic [13:0] ADDR_ACK        = 14'h010;
   localparam logic [13:0] ADDR_ACK_END    = 14'h013;
   localparam logic [13:0] ADDR_EOI        = 14'h018;
   localparam logic [13:0] ADDR_EOI_END    = 14'h01B;
   localparam logic [13:0] ADDR_SOFT       = 14'h020;
   localparam logic [13:0] ADDR_SOFT_END   = 14'h027;
   localparam logic [13:0] ADDR_PRIO       = 14'h040;

   localparam logic [31:0] BASE_MASK_8 = 32'hFFFF_F000;
   localparam logic [31:0] BASE_MASK_4 = 32'hFFFF_F800;
   localparam logic [3:0]  PRIO_MAX    = 4'hF;
   localparam int          SOFT_COUNT  = 8;

endpackage

### design/priority_interrupt_controller_unit.sv
// Priority interrupt controller: register window, source table memory and priority stack.
// Plain register accesses go from idle straight to the done state; source priority accesses,
// software interrupt writes and line events pass a read and a write state for each byte.
// An acknowledge read or a change of current priority to any value but PRIO_MAX scans
// the source memory, one entry a cycle through its single read port.
// One word is worked on at a time; the result register frees the input as soon as it is loaded.
// After reset a clearing pass zeroes every entry of the source memory; no word is taken.
module priority_interrupt_controller_unit #(
   parameter int NUM_SOURCES = 332,
   parameter int STACK_DEPTH = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [13:0] req_address,
   input  logic [2:0]  req_access_size,
   input  logic [31:0] req_write_data,
   input  logic [8:0]  req_source_index,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_request,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int IDX_W  = $clog2(NUM_SOURCES);
   localparam int KW     = IDX_W + 1;
   localparam int SCAN_W = $clog2(NUM_SOURCES + 1);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int PRIO_LIMIT = 64 + NUM_SOURCES;

   pic_pkg::state_type state_ff, state_in;
   pic_pkg::op_type    op_ff, op_in;

   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              ves_ff, ves_in;
   logic [31:0]       base_ff, base_in;
   logic [3:0]        cur_ff, cur_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [3:0]        stack_ff [STACK_DEPTH];
   logic [3:0]        stack_in [STACK_DEPTH];
   logic [8:0]        vec_ff, vec_in;
   logic              irq_ff, irq_in;
   logic [7:0]        soft_ff, soft_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_irq_ff, rsp_irq_in;

   logic [31:0]       res_ff, res_in;
   logic [31:0]       data_ff, data_in;
   logic [2:0]        n_ff, n_in;
   logic [1:0]        bsel_ff, bsel_in;
   logic [KW-1:0]     basek_ff, basek_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [1:0]        off_ff, off_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              sv_ff, sv_in;
   logic [IDX_W-1:0]  sidx_ff, sidx_in;
   logic [3:0]        best_ff, best_in;
   logic [IDX_W-1:0]  hit_ff, hit_in;
   logic              found_ff, found_in;
   logic              scan_ack_ff, scan_ack_in;

   // Source table: pending flag in bit 4, priority in bits 3..0.
   logic [4:0]        mem [NUM_SOURCES];
   logic [4:0]        mem_q_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   logic [4:0]        mem_wdata;

   logic              accept;

   assign req_stall       = (state_ff != pic_pkg::ST_IDLE);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_request = rsp_irq_ff;

   always_comb begin
      logic [2:0]    n_eff;
      logic [13:0]   kb;
      logic [3:0]    newp;
      logic          chg;
      logic [KW-1:0] k_cur;
      logic          k_ok;
      logic [7:0]    bval;
      logic [8:0]    vec_fin;
      logic [31:0]   ack_val;
      logic [31:0]   mask;

      state_in     = state_ff;
      op_in        = op_ff;
      clr_in       = clr_ff;
      ves_in       = ves_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      stack_in     = stack_ff;
      vec_in       = vec_ff;
      irq_in       = irq_ff;
      soft_in      = soft_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;
      res_in       = res_ff;
      data_in      = data_ff;
      n_in         = n_ff;
      bsel_in      = bsel_ff;
      basek_in     = basek_ff;
      k_in         = k_ff;
      off_in       = off_ff;
      scan_in      = scan_ff;
      sv_in        = sv_ff;
      sidx_in      = sidx_ff;
      best_in      = best_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      scan_ack_in  = scan_ack_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      n_eff        = 3'd1;
      kb           = '0;
      newp         = '0;
      chg          = 1'b0;
      k_cur        = basek_ff + KW'(bsel_ff);
      k_ok         = 1'b0;
      bval         = data_ff[{bsel_ff, 3'b000} +: 8];
      vec_fin      = vec_ff;
      ack_val      = '0;
      mask         = '1;

      if (csr_write_enable) begin
         case (csr_index)
            pic_pkg::CSR_VEC_SIZE: ves_in = csr_write_data[0];
            pic_pkg::CSR_VEC_BASE: base_in = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pic_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == IDX_W'(NUM_SOURCES - 1)) begin
               state_in = pic_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         pic_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_access_size == 3'd0) begin
                  n_eff = 3'd1;
               end else if (req_access_size > 3'd4) begin
                  n_eff = 3'd4;
               end else begin
                  n_eff = req_access_size;
               end
               n_in     = n_eff;
               res_in   = '0;
               data_in  = req_write_data;
               bsel_in  = '0;
               state_in = pic_pkg::ST_DONE;
               if (req_command == pic_pkg::CMD_READ) begin
                  if (req_address <= pic_pkg::ADDR_CFG_END) begin
                     res_in = {26'b0, ves_ff, 5'b0} >> {req_address[1:0], 3'b000};
                  end else if (req_address >= pic_pkg::ADDR_CURPRI &&
                               req_address <= pic_pkg::ADDR_CURPRI_END) begin
                     res_in = {28'b0, cur_ff} >> {req_address[1:0], 3'b000};
                  end else if (req_address >= pic_pkg::ADDR_ACK &&
                               req_address <= pic_pkg::ADDR_ACK_END) begin
                     // Save the current priority and drop the request before the search.
                     sp_in = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
                     stack_in[sp_in] = cur_ff;
                     irq_in      = 1'b0;
                     off_in      = req_address[1:0];
                     best_in     = cur_ff;
                     found_in    = 1'b0;
                     scan_ack_in = 1'b1;
                     scan_in     = '0;
                     sv_in       = 1'b0;
                     state_in    = pic_pkg::ST_SCAN;
                  end else if (req_address >= pic_pkg::ADDR_SOFT &&
                               req_address <= pic_pkg::ADDR_SOFT_END) begin
                     for (int i = 0; i < 4; i++) begin
                        kb = req_address - pic_pkg::ADDR_SOFT + 14'(i);
                        if (3'(i) < n_eff && kb < 14'(pic_pkg::SOFT_COUNT)) begin
                           res_in[8*i +: 8] = {7'b0, soft_ff[kb[2:0]]};
                        end
                     end
                  end else if (req_address >= pic_pkg::ADDR_PRIO &&
                               req_address < 14'(PRIO_LIMIT)) begin
                     op_in    = pic_pkg::OP_PRIO_RD;
                     basek_in = KW'(req_address - pic_pkg::ADDR_PRIO);
                     state_in = pic_pkg::ST_BYTE_RD;
                  end
               end else if (req_command == pic_pkg::CMD_WRITE) begin
                  if (req_address == pic_pkg::ADDR_CFG) begin
                     ves_in = req_write_data[5];
                  end else if (req_address == pic_pkg::ADDR_CURPRI) begin
                     newp = req_write_data[3:0];
                     chg  = 1'b1;
                  end else if (req_address >= pic_pkg::ADDR_ACK &&
                               req_address <= pic_pkg::ADDR_ACK_END) begin
                     for (int i = 0; i < 4; i++) begin
                        kb = req_address - pic_pkg::ADDR_ACK + 14'(i);
                        if (3'(i) < n_eff && kb < 14'd4) begin
                           base_in[{kb[1:0], 3'b000} +: 8] = req_write_data[8*i +: 8];
                        end
                     end
                  end else if (req_address >= pic_pkg::ADDR_EOI &&
                               req_address <= pic_pkg::ADDR_EOI_END) begin
                     newp = stack_ff[sp_ff];
                     stack_in[sp_ff] = '0;
                     sp_in = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
                     chg   = 1'b1;
                  end else if (req_address >= pic_pkg::ADDR_SOFT &&
                               req_address <= pic_pkg::ADDR_SOFT_END) begin
                     op_in    = pic_pkg::OP_SOFT_WR;
                     basek_in = KW'(req_address - pic_pkg::ADDR_SOFT);
                     state_in = pic_pkg::ST_BYTE_RD;
                  end else if (req_address >= pic_pkg::ADDR_PRIO &&
                               req_address < 14'(PRIO_LIMIT)) begin
                     op_in    = pic_pkg::OP_PRIO_WR;
                     basek_in = KW'(req_address - pic_pkg::ADDR_PRIO);
                     state_in = pic_pkg::ST_BYTE_RD;
                  end
               end else if (req_command == pic_pkg::CMD_LINE) begin
                  if (10'(req_source_index) < 10'(NUM_SOURCES)) begin
                     op_in    = pic_pkg::OP_LINE;
                     basek_in = KW'(req_source_index);
                     data_in  = {31'b0, req_line_level};
                     n_in     = 3'd1;
                     state_in = pic_pkg::ST_BYTE_RD;
                  end
               end
               // A new current priority looks for a pending source above it.
               if (chg && newp != cur_ff) begin
                  cur_in = newp;
                  if (newp != pic_pkg::PRIO_MAX) begin
                     best_in     = newp;
                     found_in    = 1'b0;
                     scan_ack_in = 1'b0;
                     scan_in     = '0;
                     sv_in       = 1'b0;
                     state_in    = pic_pkg::ST_SCAN;
                  end
               end
            end
         end

         pic_pkg::ST_BYTE_RD: begin
            if (op_ff == pic_pkg::OP_SOFT_WR) begin
               k_ok = (k_cur < KW'(pic_pkg::SOFT_COUNT));
            end else begin
               k_ok = (k_cur < KW'(NUM_SOURCES));
            end
            if (k_ok) begin
               mem_raddr = k_cur[IDX_W-1:0];
               k_in      = k_cur[IDX_W-1:0];
               state_in  = pic_pkg::ST_BYTE_WR;
            end else begin
               state_in = pic_pkg::ST_DONE;
            end
         end

         pic_pkg::ST_BYTE_WR: begin
            mem_waddr = k_ff;
            case (op_ff)
               pic_pkg::OP_PRIO_RD: begin
                  res_in[{bsel_ff, 3'b000} +: 8] = {4'b0, mem_q_ff[3:0]};
               end
               pic_pkg::OP_PRIO_WR: begin
                  mem_we    = 1'b1;
                  mem_wdata = {mem_q_ff[4], bval[3:0]};
                  if (bval[3:0] > cur_ff && mem_q_ff[4]) begin
                     irq_in = 1'b1;
                  end
               end
               pic_pkg::OP_SOFT_WR: begin
                  // Clear comes first, then set, so a byte with both bits ends set.
                  mem_we    = 1'b1;
                  mem_wdata = mem_q_ff;
                  if (bval[0]) begin
                     mem_wdata[4] = 1'b0;
                     soft_in[k_ff[2:0]] = 1'b0;
                  end
                  if (bval[1]) begin
                     mem_wdata[4] = 1'b1;
                     soft_in[k_ff[2:0]] = 1'b1;
                     if (mem_q_ff[3:0] > cur_ff) begin
                        irq_in = 1'b1;
                     end
                  end
               end
               pic_pkg::OP_LINE: begin
                  mem_we    = 1'b1;
                  mem_wdata = {data_ff[0], mem_q_ff[3:0]};
                  if (data_ff[0] && mem_q_ff[3:0] > cur_ff) begin
                     irq_in = 1'b1;
                  end
               end
               default: ;
            endcase
            if ({1'b0, bsel_ff} + 3'd1 == n_ff) begin
               state_in = pic_pkg::ST_DONE;
            end else begin
               bsel_in  = bsel_ff + 1'b1;
               state_in = pic_pkg::ST_BYTE_RD;
            end
         end

         pic_pkg::ST_SCAN: begin
            if (scan_ff < SCAN_W'(NUM_SOURCES)) begin
               mem_raddr = scan_ff[IDX_W-1:0];
               sidx_in   = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
               sv_in     = 1'b1;
            end else begin
               sv_in = 1'b0;
            end
            // Strictly greater keeps the lowest-numbered source among equals.
            if (sv_ff && mem_q_ff[4] && mem_q_ff[3:0] > best_ff) begin
               best_in  = mem_q_ff[3:0];
               hit_in   = sidx_ff;
               found_in = 1'b1;
            end
            if (scan_ff == SCAN_W'(NUM_SOURCES) && !sv_ff) begin
               if (scan_ack_ff) begin
                  if (found_ff) begin
                     vec_fin = 9'(hit_ff);
                     cur_in  = best_ff;
                  end
                  vec_in = vec_fin;
                  if (ves_ff) begin
                     ack_val = {20'b0, vec_fin, 3'b000} | (base_ff & pic_pkg::BASE_MASK_8);
                  end else begin
                     ack_val = {21'b0, vec_fin, 2'b00} | (base_ff & pic_pkg::BASE_MASK_4);
                  end
                  res_in = ack_val >> {off_ff, 3'b000};
               end else if (found_ff) begin
                  irq_in = 1'b1;
               end
               state_in = pic_pkg::ST_DONE;
            end
         end

         pic_pkg::ST_DONE: begin
            case (n_ff)
               3'd1:    mask = 32'h0000_00FF;
               3'd2:    mask = 32'h0000_FFFF;
               3'd3:    mask = 32'h00FF_FFFF;
               default: mask = 32'hFFFF_FFFF;
            endcase
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff & mask;
               rsp_irq_in   = irq_ff;
               state_in     = pic_pkg::ST_IDLE;
            end
         end

         default: state_in = pic_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pic_pkg::ST_CLEAR;
         clr_ff       <= '0;
         ves_ff       <= 1'b0;
         base_ff      <= '0;
         cur_ff       <= pic_pkg::PRIO_MAX;
         sp_ff        <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            stack_ff[i] <= '0;
         end
         vec_ff       <= '0;
         irq_ff       <= 1'b0;
         soft_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ves_ff       <= ves_in;
         base_ff      <= base_in;
         cur_ff       <= cur_in;
         sp_ff        <= sp_in;
         stack_ff     <= stack_in;
         vec_ff       <= vec_in;
         irq_ff       <= irq_in;
         soft_ff      <= soft_in;
         rsp_valid_ff <= rsp_valid_in;
         sv_ff        <= sv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
      res_ff      <= res_in;
      data_ff     <= data_in;
      n_ff        <= n_in;
      bsel_ff     <= bsel_in;
      basek_ff    <= basek_in;
      k_ff        <= k_in;
      off_ff      <= off_in;
      scan_ff     <= scan_in;
      sidx_ff     <= sidx_in;
      best_ff     <= best_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      scan_ack_ff <= scan_ack_in;
   end

   a_stack_pos: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, sp_ff} < (SP_W + 1)'(STACK_DEPTH)))
      else $error("stack position out of range");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pic_pkg::ST_CLEAR) |-> req_stall)
      else $error("word taken during clearing pass");

   a_ack_line_low: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pic_pkg::ST_SCAN && scan_ack_ff) |-> !irq_ff)
      else $error("request line high during acknowledge search");

   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == pic_pkg::ST_CLEAR || state_ff == pic_pkg::ST_BYTE_WR))
      else $error("source memory written outside clear or update");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pic_pkg::ST_DONE))
      else $error("result word appeared without a finished item");

endmodule

### tb/priority_interrupt_controller_unit_test.sv
// Self-checking testbench for the priority interrupt controller unit.
module priority_interrupt_controller_unit_test;

   localparam int          NUM_SRC    = 332;
   localparam int          STACK_SIZE = 14;
   localparam int          STALL_LIMIT = 20000;
   localparam logic [1:0]  CMD_NONE   = 2'd3;

   typedef struct {
      logic [31:0] data;
      logic        irq;
   } pic_reply_type;

   class pic_scoreboard;
      bit [3:0]    prio [NUM_SRC];
      bit          pend [NUM_SRC];
      bit          soft_flag [pic_pkg::SOFT_COUNT];
      bit [3:0]    cur_prio;
      bit [3:0]    saved [STACK_SIZE];
      int unsigned sp;
      bit [8:0]    vec;
      bit          irq_line;
      bit          size8;
      bit [31:0]   base;
      pic_reply_type replies [$];
      int          errors;
      int          checked;
      int          acks;

      function new();
         foreach (prio[i]) begin
            prio[i] = 0;
            pend[i] = 0;
         end
         foreach (soft_flag[i]) soft_flag[i] = 0;
         foreach (saved[i]) saved[i] = 0;
         cur_prio = pic_pkg::PRIO_MAX;
         sp = 0;
         vec = 0;
         irq_line = 0;
         size8 = 0;
         base = 0;
         errors = 0;
         checked = 0;
         acks = 0;
      endfunction

      function void write_register(logic idx, logic [31:0] value);
         if (idx == pic_pkg::CSR_VEC_SIZE) size8 = value[0];
         else base = value;
      endfunction

      function void rescan();
         if (cur_prio == pic_pkg::PRIO_MAX) return;
         for (int i = 0; i < NUM_SRC; i++)
            if (pend[i] && prio[i] > cur_prio) begin
               irq_line = 1;
               return;
            end
      endfunction

      function void drive_line(int unsigned src, bit level);
         if (src >= NUM_SRC) return;
         pend[src] = level;
         if (level && prio[src] > cur_prio) irq_line = 1;
      endfunction

      function void new_priority(bit [3:0] p);
         if (p != cur_prio) begin
            cur_prio = p;
            rescan();
         end
      endfunction

      function bit [31:0] acknowledge();
         bit [3:0]    best;
         bit          found;
         int unsigned hit;
         best = cur_prio;
         found = 0;
         hit = 0;
         acks++;
         sp = (sp + 1) % STACK_SIZE;
         saved[sp] = cur_prio;
         irq_line = 0;
         for (int i = 0; i < NUM_SRC; i++)
            if (pend[i] && prio[i] > best) begin
               best = prio[i];
               hit = i;
               found = 1;
            end
         if (found) begin
            vec = hit[8:0];
            cur_prio = best;
         end
         if (size8) return (32'(vec) << 3) | (base & pic_pkg::BASE_MASK_8);
         return (32'(vec) << 2) | (base & pic_pkg::BASE_MASK_4);
      endfunction

      function bit [31:0] bus_read(int unsigned a, int unsigned n);
         bit [31:0] r;
         r = 0;
         if (a <= pic_pkg::ADDR_CFG_END)
            r = (size8 ? 32'h20 : 32'h0) >> (8 * a);
         else if (a >= pic_pkg::ADDR_CURPRI && a <= pic_pkg::ADDR_CURPRI_END)
            r = 32'(cur_prio) >> (8 * (a - pic_pkg::ADDR_CURPRI));
         else if (a >= pic_pkg::ADDR_ACK && a <= pic_pkg::ADDR_ACK_END)
            r = acknowledge() >> (8 * (a - pic_pkg::ADDR_ACK));
         else if (a >= pic_pkg::ADDR_SOFT && a <= pic_pkg::ADDR_SOFT_END) begin
            for (int i = 0; i < n; i++)
               if (a - pic_pkg::ADDR_SOFT + i < pic_pkg::SOFT_COUNT)
                  r |= 32'(soft_flag[a - pic_pkg::ADDR_SOFT + i]) << (8 * i);
         end else if (a >= pic_pkg::ADDR_PRIO && a < pic_pkg::ADDR_PRIO + NUM_SRC) begin
            for (int i = 0; i < n; i++)
               if (a - pic_pkg::ADDR_PRIO + i < NUM_SRC)
                  r |= 32'(prio[a - pic_pkg::ADDR_PRIO + i]) << (8 * i);
         end
         return r;
      endfunction

      function void bus_write(int unsigned a, int unsigned n, bit [31:0] v);
         int unsigned k;
         bit [7:0]    b;
         if (a == pic_pkg::ADDR_CFG)
            size8 = v[5];
         else if (a == pic_pkg::ADDR_CURPRI)
            new_priority(v[3:0]);
         else if (a >= pic_pkg::ADDR_ACK && a <= pic_pkg::ADDR_ACK_END) begin
            for (int i = 0; i < n; i++) begin
               k = a - pic_pkg::ADDR_ACK + i;
               if (k < 4) base[8*k +: 8] = v[8*i +: 8];
            end
         end else if (a >= pic_pkg::ADDR_EOI && a <= pic_pkg::ADDR_EOI_END) begin
            // The popped slot is cleared and the position steps back with wraparound.
            if (sp >= STACK_SIZE) sp = 0;
            b = saved[sp];
            saved[sp] = 0;
            sp = (sp == 0) ? STACK_SIZE - 1 : sp - 1;
            new_priority(b[3:0]);
         end else if (a >= pic_pkg::ADDR_SOFT && a <= pic_pkg::ADDR_SOFT_END) begin
            for (int i = 0; i < n; i++) begin
               k = a - pic_pkg::ADDR_SOFT + i;
               b = v[8*i +: 8];
               if (k < pic_pkg::SOFT_COUNT) begin
                  if (b[0]) begin
                     soft_flag[k] = 0;
                     drive_line(k, 0);
                  end
                  if (b[1]) begin
                     soft_flag[k] = 1;
                     drive_line(k, 1);
                  end
               end
            end
         end else if (a >= pic_pkg::ADDR_PRIO && a < pic_pkg::ADDR_PRIO + NUM_SRC) begin
            for (int i = 0; i < n; i++) begin
               k = a - pic_pkg::ADDR_PRIO + i;
               if (k < NUM_SRC) begin
                  prio[k] = v[8*i +: 4];
                  if (prio[k] > cur_prio && pend[k]) irq_line = 1;
               end
            end
         end
      endfunction

      function void note_request(logic [1:0] cmd, logic [13:0] addr, logic [2:0] size,
                                 logic [31:0] data, logic [8:0] src, logic level);
         pic_reply_type rep;
         int unsigned   n;
         n = size;
         if (n == 0) n = 1;
         if (n > 4) n = 4;
         rep.data = 0;
         if (cmd == pic_pkg::CMD_READ) begin
            rep.data = bus_read(addr, n);
            if (n < 4) rep.data &= (32'h1 << (8 * n)) - 1;
         end else if (cmd == pic_pkg::CMD_WRITE)
            bus_write(addr, n, data);
         else if (cmd == pic_pkg::CMD_LINE)
            drive_line(src, level);
         rep.irq = irq_line;
         replies.push_back(rep);
      endfunction

      function void check_response(logic [31:0] data, logic irq);
         pic_reply_type rep;
         checked++;
         if (replies.size() == 0) begin
            $error("unexpected word: read_data %h irq_request %b", data, irq);
            errors++;
            return;
         end
         rep = replies.pop_front();
         if (data !== rep.data) begin
            $error("read_data: expected %h, got %h", rep.data, data);
            errors++;
         end
         if (irq !== rep.irq) begin
            $error("irq_request: expected %b, got %b", rep.irq, irq);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [13:0] req_address;
   logic [2:0]  req_access_size;
   logic [31:0] req_write_data;
   logic [8:0]  req_source_index;
   logic        req_line_level;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_request;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   pic_scoreboard sb = new();
   int tx_idle_pct;
   int rx_stall_pct;
   int hold_cycles;
   int quiet_cycles;

   priority_interrupt_controller_unit dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver stalls: either a counted long hold-off or random stalls.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_command, req_address, req_access_size, req_write_data,
                         req_source_index, req_line_level);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_read_data, rsp_irq_request);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_word(logic [1:0] cmd, logic [13:0] addr, logic [2:0] size,
                            logic [31:0] data, logic [8:0] src, logic level);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_address      <= addr;
      req_access_size  <= size;
      req_write_data   <= data;
      req_source_index <= src;
      req_line_level   <= level;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.replies.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      sb.write_register(idx, value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [8:0] pick_source();
      if ($urandom_range(99) < 70) return 9'($urandom_range(15));
      return 9'($urandom_range(511));
   endfunction

   task automatic random_word();
      int          sel;
      logic [13:0] addr;
      logic [2:0]  size;
      logic [31:0] data;
      logic [8:0]  src;
      sel  = $urandom_range(99);
      size = 3'($urandom_range(7));
      data = $urandom;
      src  = pick_source();
      if (sel < 12)
         send_word(pic_pkg::CMD_READ,
                   pic_pkg::ADDR_ACK + 14'($urandom_range(3) * ($urandom_range(3) == 0)),
                   size, data, src, 0);
      else if (sel < 24)
         send_word(pic_pkg::CMD_LINE, 14'($urandom), size, data, src,
                   $urandom_range(99) < 60);
      else if (sel < 36)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_PRIO + 14'($urandom_range(15)),
                   size, data, src, 0);
      else if (sel < 44)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CURPRI, size, data, src, 0);
      else if (sel < 52)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_EOI + 14'($urandom_range(3)),
                   size, data, src, 0);
      else if (sel < 58)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_SOFT + 14'($urandom_range(7)),
                   size, data, src, 0);
      else if (sel < 66) begin
         case ($urandom_range(4))
            0: addr = pic_pkg::ADDR_CFG + 14'($urandom_range(3));
            1: addr = pic_pkg::ADDR_CURPRI + 14'($urandom_range(3));
            2: addr = pic_pkg::ADDR_EOI + 14'($urandom_range(3));
            3: addr = pic_pkg::ADDR_SOFT + 14'($urandom_range(7));
            default: addr = pic_pkg::ADDR_PRIO + 14'($urandom_range(NUM_SRC + 3));
         endcase
         send_word(pic_pkg::CMD_READ, addr, size, data, src, 0);
      end else if (sel < 71)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_ACK + 14'($urandom_range(3)),
                   size, data, src, 0);
      else if (sel < 74)
         send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CFG + 14'($urandom_range(3)),
                   size, data, src, 0);
      else if (sel < 77)
         send_word(CMD_NONE, 14'($urandom), size, data, 9'($urandom), 1'($urandom));
      else if (sel < 87)
         send_word(2'($urandom_range(1)), 14'($urandom), size, data, 9'($urandom),
                   1'($urandom));
      else
         send_word(pic_pkg::CMD_WRITE,
                   pic_pkg::ADDR_PRIO + 14'($urandom_range(NUM_SRC - 4, NUM_SRC + 2)),
                   size, data, src, 0);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = pic_pkg::CMD_READ;
      req_address      = '0;
      req_access_size  = 3'd1;
      req_write_data   = '0;
      req_source_index = '0;
      req_line_level   = 1'b0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = pic_pkg::CSR_VEC_SIZE;
      csr_write_data   = '0;
      tx_idle_pct      = 0;
      rx_stall_pct     = 0;
      hold_cycles      = 0;
      quiet_cycles     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(pic_pkg::CSR_VEC_SIZE, 32'h0);
      write_csr(pic_pkg::CSR_VEC_BASE, 32'hA5A5_5A5A);

      // Directed words: register extremes, acknowledge with and without a candidate,
      // stack pop, software flags, bytes beyond a region and ignored sources.
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_CFG, 3'd4, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CFG, 3'd1, 32'h0000_0020, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_CFG, 3'd1, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CFG + 14'd1, 3'd1, 32'hFFFF_FFFF,
                9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_ACK, 3'd4, 32'h1234_5678, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CURPRI, 3'd1, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_PRIO, 3'd1, 32'h5, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_PRIO + 14'(NUM_SRC - 2), 3'd4,
                32'h0F0F_0F0F, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_LINE,  14'h0, 3'd1, 32'h0, 9'd0, 1'b1);
      send_word(pic_pkg::CMD_LINE,  14'h0, 3'd1, 32'h0, 9'(NUM_SRC - 1), 1'b1);
      send_word(pic_pkg::CMD_LINE,  14'h0, 3'd1, 32'h0, 9'd400, 1'b1);
      send_word(pic_pkg::CMD_LINE,  14'h0, 3'd1, 32'h0, 9'd511, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_ACK, 3'd4, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_ACK, 3'd7, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_EOI, 3'd1, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_EOI, 3'd2, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_SOFT, 3'd4, 32'h0202_0202, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_SOFT, 3'd0, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_SOFT + 14'd5, 3'd4, 32'h0303_0101,
                9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_SOFT + 14'd4, 3'd4, 32'h0, 9'd0, 1'b0);
      send_word(CMD_NONE,  14'h3FFF, 3'd7, 32'hFFFF_FFFF, 9'h1FF, 1'b1);
      send_word(pic_pkg::CMD_READ,  14'h030, 3'd4, 32'h0, 9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_PRIO + 14'(NUM_SRC - 1), 3'd4, 32'h0,
                9'd0, 1'b0);
      send_word(pic_pkg::CMD_WRITE, pic_pkg::ADDR_CURPRI, 3'd1, 32'hFFFF_FFFF,
                9'd0, 1'b0);
      send_word(pic_pkg::CMD_READ,  pic_pkg::ADDR_ACK_END, 3'd1, 32'h0, 9'd0, 1'b0);
      drain();

      tx_idle_pct  = 34;
      rx_stall_pct = 80;
      write_csr(pic_pkg::CSR_VEC_SIZE, 32'h1);
      write_csr(pic_pkg::CSR_VEC_BASE, 32'hFFFF_FFFF);
      for (int i = 0; i < 180; i++) begin
         // A long receiver hold-off lets the block back up while words keep coming.
         if (i == 60) hold_cycles <= 1500;
         random_word();
      end
      drain();

      tx_idle_pct  = 80;
      rx_stall_pct = 34;
      write_csr(pic_pkg::CSR_VEC_SIZE, 32'h0);
      write_csr(pic_pkg::CSR_VEC_BASE, 32'h0);
      for (int i = 0; i < 180; i++) random_word();
      drain();

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_csr(pic_pkg::CSR_VEC_SIZE, 32'h1);
      write_csr(pic_pkg::CSR_VEC_BASE, $urandom);
      for (int i = 0; i < 180; i++) random_word();
      drain();
      repeat (50) @(posedge clock);

      $display("Checked %0d result words, %0d of them acknowledges, over three idling mixes",
               sb.checked, sb.acks);
      $display("and several vector table settings; %0d mismatches.", sb.errors);
      if (sb.errors == 0 && sb.replies.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
